// ===== design/mkrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_pkg
// Shared types and constants for the multichannel K-character record deframer.
// ----------------------------------------------------------------------------
package mkrd_pkg;

  localparam int NUM_CHANNELS  = 32;
  localparam int CH_W          = 5;
  localparam int CH_IDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BYTE_W        = 8;
  localparam int PART_W        = 2 * BYTE_W;
  localparam int MASK_W        = 32;
  localparam int WORD_W        = 31;
  localparam int CHANNEL_SHIFT = 26;
  localparam logic [BYTE_W-1:0] SYNC_CHAR = 8'hFC;

  // Framing phase: out of frame, or position of the next data byte.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_B1   = 2'd1,
    PH_B2   = 2'd2,
    PH_B3   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              is_control;
    logic [BYTE_W-1:0] symbol_byte;
  } symbol_t;

  typedef struct packed {
    logic              emit;
    logic [WORD_W-1:0] word;
  } result_t;

endpackage

// ===== design/mkrd_frame_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_frame_engine
// Per-channel framing state and record assembly for one symbol per cycle while proc is high.
// ----------------------------------------------------------------------------
module mkrd_frame_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           proc,
  input  mkrd_pkg::symbol_t              item,
  input  logic [mkrd_pkg::MASK_W-1:0]    mask,
  output mkrd_pkg::result_t              res
);

  mkrd_pkg::phase_t                frame_phase    [mkrd_pkg::NUM_CHANNELS];
  logic [mkrd_pkg::PART_W-1:0]     partial_record [mkrd_pkg::NUM_CHANNELS];

  logic [mkrd_pkg::CH_IDX_W-1:0]   idx;
  logic                            in_range;
  logic                            enabled;
  mkrd_pkg::phase_t                cur_phase;
  mkrd_pkg::phase_t                phase_next;
  logic [mkrd_pkg::PART_W-1:0]     cur_part;
  logic [mkrd_pkg::PART_W-1:0]     part_next;
  logic                            wr_phase;
  logic                            wr_part;

  always_comb begin
    idx        = item.channel[mkrd_pkg::CH_IDX_W-1:0];
    in_range   = ({1'b0, item.channel} < (mkrd_pkg::CH_W+1)'(mkrd_pkg::NUM_CHANNELS));
    enabled    = in_range && mask[item.channel];
    cur_phase  = frame_phase[idx];
    cur_part   = partial_record[idx];
    phase_next = cur_phase;
    part_next  = cur_part;
    wr_phase   = 1'b0;
    wr_part    = 1'b0;
    res.emit   = 1'b0;
    res.word   = {item.channel, 2'b00, cur_part, item.symbol_byte};
    if (enabled) begin
      if (item.is_control) begin
        phase_next = (item.symbol_byte == mkrd_pkg::SYNC_CHAR) ? mkrd_pkg::PH_B1
                                                              : mkrd_pkg::PH_IDLE;
        wr_phase   = 1'b1;
      end else begin
        case (cur_phase)
          mkrd_pkg::PH_B1: begin
            part_next  = {item.symbol_byte, {mkrd_pkg::BYTE_W{1'b0}}};
            phase_next = mkrd_pkg::PH_B2;
            wr_phase   = 1'b1;
            wr_part    = 1'b1;
          end
          mkrd_pkg::PH_B2: begin
            part_next  = cur_part | {{mkrd_pkg::BYTE_W{1'b0}}, item.symbol_byte};
            phase_next = mkrd_pkg::PH_B3;
            wr_phase   = 1'b1;
            wr_part    = 1'b1;
          end
          mkrd_pkg::PH_B3: begin
            phase_next = mkrd_pkg::PH_B1;
            wr_phase   = 1'b1;
            res.emit   = 1'b1;
          end
          default: begin
            // out of frame: data byte dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mkrd_pkg::NUM_CHANNELS; i++) begin
        frame_phase[i] <= mkrd_pkg::PH_IDLE;
      end
    end else if (proc && wr_phase) begin
      frame_phase[idx] <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && wr_part) begin
      partial_record[idx] <= part_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_data_only: assert property (@(posedge clk) disable iff (rst)
    res.emit |-> (!item.is_control && enabled))
    else $error("record emitted for control or disabled symbol");
  a_sync_restarts: assert property (@(posedge clk) disable iff (rst)
    (proc && enabled && item.is_control && item.symbol_byte == mkrd_pkg::SYNC_CHAR)
    |=> frame_phase[$past(idx)] == mkrd_pkg::PH_B1)
    else $error("sync character did not restart framing");
  a_emit_rearms: assert property (@(posedge clk) disable iff (rst)
    (proc && res.emit) |=> frame_phase[$past(idx)] == mkrd_pkg::PH_B1)
    else $error("channel not rearmed after record");
`endif

endmodule

// ===== design/mkrd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_out_stage
// Result register holding one record until the consumer takes it.
// ----------------------------------------------------------------------------
module mkrd_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [mkrd_pkg::WORD_W-1:0]   word_in,
  input  logic                          stall,
  output logic                          valid,
  output logic [mkrd_pkg::WORD_W-1:0]   word_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_out <= word_in;
    end
  end

endmodule

// ===== design/multichannel_kchar_record_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_kchar_record_deframer
// Per-channel K-character synchronized deframer of 24-bit records.
// ----------------------------------------------------------------------------
// Takes one decoded 8b10b symbol per cycle (channel, control flag, byte) and
// keeps a framing phase per channel. K-char 0xFC (re)starts a frame, any other
// control character drops sync, and data out of frame is dropped. Every three
// in-frame data bytes form one record, MSB first, emitted as record_word:
// channel in 30..26, zeros in 25..24, record in 23..0. Channels whose bit in
// channel_enable_mask is clear are ignored. Throughput is one symbol per
// cycle while symbol_stall is low; a record goes via the symbol register to
// the result register, waiting while an earlier one is held by a record stall.
// The per-channel state update sits between the symbol register
// and the result register, so an input stall is only raised while a result
// is ready to load and the result register is full and stalled.
// Write the enable mask only while the block is idle.
// ----------------------------------------------------------------------------
module multichannel_kchar_record_deframer (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mkrd_pkg::MASK_W-1:0]   cfg_data,
  // symbol channel
  input  logic                          symbol_valid,
  output logic                          symbol_stall,
  input  logic [mkrd_pkg::CH_W-1:0]     channel,
  input  logic                          is_control,
  input  logic [mkrd_pkg::BYTE_W-1:0]   symbol_byte,
  // record channel
  output logic                          record_valid,
  input  logic                          record_stall,
  output logic [mkrd_pkg::WORD_W-1:0]   record_word
);

  // Enable mask register; the write port never back-pressures.
  logic [mkrd_pkg::MASK_W-1:0] channel_enable_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      channel_enable_mask <= cfg_data;
    end
  end

  // Symbol register: one request deep, processed once it can advance.
  logic              s1_valid;
  mkrd_pkg::symbol_t s1_item;
  mkrd_pkg::result_t res;
  logic              s1_advance;
  logic              sym_accept;

  // Advance unless a record must load while the result register is stuck.
  assign s1_advance   = s1_valid && (!res.emit || !record_valid || !record_stall);
  assign symbol_stall = s1_valid && !s1_advance;
  assign sym_accept   = symbol_valid && !symbol_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sym_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_accept) begin
      s1_item.channel     <= channel;
      s1_item.is_control  <= is_control;
      s1_item.symbol_byte <= symbol_byte;
    end
  end

  // Framing state is read and updated only when the request advances,
  // so back-to-back symbols of the same channel see the updated phase.
  mkrd_frame_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .proc (s1_advance),
    .item (s1_item),
    .mask (channel_enable_mask),
    .res  (res)
  );

  mkrd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_advance && res.emit),
    .word_in  (res.word),
    .stall    (record_stall),
    .valid    (record_valid),
    .word_out (record_word)
  );

`ifndef SYNTHESIS
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    symbol_stall |-> (s1_valid && res.emit && record_valid))
    else $error("symbol stall without a blocked record");
  a_no_record_overwrite: assert property (@(posedge clk) disable iff (rst)
    (record_valid && record_stall) |=> (record_valid && $stable(record_word)))
    else $error("pending record lost or overwritten");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && res.emit) |-> (!record_valid || !record_stall))
    else $error("record loaded into a full result register");
`endif

endmodule
